@@ sv/nfa_pkg.sv @@
// Shared types, constants and helper functions for the next-fit ID allocator.
// Used by nfa_map_mem and next_fit_id_allocator_core; no dependencies.

package nfa_pkg;

    // Pool geometry: one bit per identifier, grouped into words.
    localparam int POOL_SIZE = 1024;
    localparam int ID_W      = 10;
    localparam int WORD_W    = 32;
    localparam int WORD_CNT  = POOL_SIZE / WORD_W;
    localparam int ADDR_W    = $clog2(WORD_CNT);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int STEP_W    = $clog2(WORD_CNT + 1);

    // A scan reads every word once and then the start word again.
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_CNT);

    // Identifiers whose low byte matches this code are permanently reserved.
    localparam logic [7:0] RESV_CODE = 8'h0D;
    localparam logic [ID_W-1:0] FIRST_ID = ID_W'(1);

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_RESET   = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL
    } t_state;

    // Access bundle from the controller to the map memory.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              clear;
    } t_mem_req;

    // Power-on contents of one map word: reserved identifiers are marked used.
    function automatic logic [WORD_W-1:0] resv_word(input logic [ADDR_W-1:0] addr);
        logic [WORD_W-1:0] w;
        logic [ID_W-1:0]   id;
        w = '0;
        for (int b = 0; b < WORD_W; b++) begin
            id   = ID_W'({addr, BIT_W'(b)});
            w[b] = (id[7:0] == RESV_CODE);
        end
        return w;
    endfunction

    // Index of the lowest set bit; the caller checks that some bit is set.
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

@@ sv/nfa_map_mem.sv @@
// Used/free bitmap storage: a word-wide synchronous RAM plus one valid flag per word.
// A word whose flag is clear reads as its power-on pattern. Depends on nfa_pkg.

module nfa_map_mem import nfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_req          i_req,
    output logic [WORD_W-1:0] o_rd_word
);

    logic [WORD_W-1:0]   r_mem [WORD_CNT];
    logic [WORD_W-1:0]   r_rd_data;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [WORD_CNT-1:0] r_valid;

    // Memory array: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // Valid flags: cleared by reset or a pool reset, set when a word is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Words never written since the last clear show their reserved pattern.
    assign o_rd_word = r_valid[r_rd_addr] ? r_rd_data : resv_word(r_rd_addr);

endmodule

@@ sv/next_fit_id_allocator_core.sv @@
// Next-fit identifier allocator: a request starts when start is high and busy is low,
// and its one result appears for a single cycle with o_done high; the receiver cannot
// stall it, so it must take every result. An allocate reads 32-bit map words from the
// bitmap RAM one after another, starting at the word that holds the identifier after
// the cursor and ending at the first word holding a free identifier; the start word is
// checked a second time, below the start bit, when no free identifier was found before.
// A release reads and rewrites one word for its read-modify-write; a pool reset, an
// out-of-range release and kind 3 finish from idle without raising busy. The result
// shows the cycle after the item's last busy cycle. A pool reset takes effect
// at once through per-word valid flags, so there is no clearing pass after reset.
// Depends on nfa_pkg and nfa_map_mem.

module next_fit_id_allocator_core import nfa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      i_kind,
    input  logic [ID_W-1:0] i_req_id,
    output logic            o_done,
    output logic [ID_W-1:0] o_granted_id,
    output logic [1:0]      o_status
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [ADDR_W-1:0] r_word, n_word;
    logic [BIT_W-1:0]  r_start_bit, n_start_bit;
    logic [ID_W-1:0]   r_cursor, n_cursor;
    logic [ID_W-1:0]   r_rel_id, n_rel_id;
    logic              r_done, n_done;
    logic [ID_W-1:0]   r_gid, n_gid;
    t_status           r_status, n_status;

    t_mem_req          mem_req;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] scan_mask;
    logic [WORD_W-1:0] free_bits;
    logic [BIT_W-1:0]  free_idx;
    logic [ID_W-1:0]   start_id;
    logic              rel_in_range;

    nfa_map_mem u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mem_req),
        .o_rd_word(rd_word)
    );

    // The scan begins just past the cursor; the 10-bit wrap lands on identifier 0,
    // which the word mask always excludes.
    assign start_id     = r_cursor + FIRST_ID;
    assign rel_in_range = (i_req_id >= FIRST_ID) && (32'(i_req_id) < POOL_SIZE);

    // First pass over the start word looks at and above the start bit, the closing
    // pass below it, and identifier 0 is never a candidate.
    always_comb begin
        if (r_step == '0) begin
            scan_mask = {WORD_W{1'b1}} << r_start_bit;
        end else if (r_step == LAST_STEP) begin
            scan_mask = ~({WORD_W{1'b1}} << r_start_bit);
        end else begin
            scan_mask = {WORD_W{1'b1}};
        end
        if (r_word == '0) begin
            scan_mask[0] = 1'b0;
        end
    end

    assign free_bits = ~rd_word & scan_mask;
    assign free_idx  = first_set(free_bits);

    // Next state, memory accesses and result.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_word      = r_word;
        n_start_bit = r_start_bit;
        n_cursor    = r_cursor;
        n_rel_id    = r_rel_id;
        n_done      = 1'b0;
        n_gid       = r_gid;
        n_status    = r_status;
        mem_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_kind'(i_kind))
                        KIND_ALLOC: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = start_id[ID_W-1:BIT_W];
                            n_word          = start_id[ID_W-1:BIT_W];
                            n_start_bit     = start_id[BIT_W-1:0];
                            n_step          = '0;
                            n_state         = S_SCAN;
                        end
                        KIND_RELEASE: begin
                            if (rel_in_range) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = i_req_id[ID_W-1:BIT_W];
                                n_rel_id        = i_req_id;
                                n_state         = S_REL;
                            end else begin
                                n_done   = 1'b1;
                                n_gid    = '0;
                                n_status = ST_RANGE;
                            end
                        end
                        KIND_RESET: begin
                            mem_req.clear = 1'b1;
                            n_cursor      = FIRST_ID;
                            n_done        = 1'b1;
                            n_gid         = '0;
                            n_status      = ST_DONE;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_gid    = '0;
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (free_bits != '0) begin
                    // Grant the lowest free identifier in this word.
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_word;
                    mem_req.wr_data = rd_word | (WORD_W'(1) << free_idx);
                    n_cursor        = {r_word, free_idx};
                    n_done          = 1'b1;
                    n_gid           = {r_word, free_idx};
                    n_status        = ST_DONE;
                    n_state         = S_IDLE;
                end else if (r_step == LAST_STEP) begin
                    n_done   = 1'b1;
                    n_gid    = '0;
                    n_status = ST_EXHAUSTED;
                    n_state  = S_IDLE;
                end else begin
                    // Fetch the following word, wrapping around the map.
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_word + ADDR_W'(1);
                    n_word          = r_word + ADDR_W'(1);
                    n_step          = r_step + STEP_W'(1);
                end
            end

            S_REL: begin
                // Reserved identifiers stay used; anything else is freed.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_rel_id[ID_W-1:BIT_W];
                if (r_rel_id[7:0] == RESV_CODE) begin
                    mem_req.wr_data = rd_word;
                end else begin
                    mem_req.wr_data = rd_word & ~(WORD_W'(1) << r_rel_id[BIT_W-1:0]);
                end
                n_done   = 1'b1;
                n_gid    = '0;
                n_status = ST_DONE;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= FIRST_ID;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_done   <= n_done;
        end
    end

    // Scan bookkeeping and result payload.
    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_word      <= n_word;
        r_start_bit <= n_start_bit;
        r_rel_id    <= n_rel_id;
        r_gid       <= n_gid;
        r_status    <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_granted_id = r_gid;
    assign o_status     = r_status;

    // A granted identifier is never zero's slot or a reserved one.
    a_grant_not_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted_id != '0) |-> (o_granted_id[7:0] != RESV_CODE))
        else $error("granted a reserved identifier");

    // Only a successful allocate returns a nonzero identifier.
    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted_id != '0) |-> (o_status == ST_DONE))
        else $error("nonzero identifier with failing status");

    // The cursor follows the identifier just granted.
    a_cursor_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted_id != '0) |-> (r_cursor == o_granted_id))
        else $error("cursor does not match granted identifier");

    // The map is written only while a request is being worked on.
    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (r_state == S_SCAN || r_state == S_REL))
        else $error("map write outside scan or release");

    // A scan never runs past its closing pass.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step <= LAST_STEP))
        else $error("scan step out of range");

endmodule

@@ tb/sv/tb_next_fit_id_allocator_core.sv @@
// Self-checking testbench for next_fit_id_allocator_core: allocate, release and pool reset
// requests are checked against a next-fit bitmap predictor kept in a small scoreboard class.
// Depends on nfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_next_fit_id_allocator_core;
    import nfa_pkg::*;

    // Kind code that the block takes as a no-op.
    localparam logic [1:0] KIND_NOP = 2'd3;
    // Upper bound on the run.
    localparam int CYCLE_LIMIT = 400000;
    // Longest allocate plus the result cycle, with margin.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 250;

    typedef struct packed {
        logic [ID_W-1:0] granted;
        t_status         status;
    } t_id_result;

    // Tracks the pool the way the block should and holds the results still owed.
    class id_pool_scoreboard;
        bit          used_map[POOL_SIZE];
        int unsigned cursor;
        t_id_result  pending_results[$];
        int          errors;

        function new();
            errors = 0;
            restore_pool();
        endfunction

        function bit is_reserved(int unsigned id);
            return (id & 32'h00FF) == RESV_CODE;
        endfunction

        function void restore_pool();
            for (int k = 0; k < POOL_SIZE; k++) begin
                used_map[k] = is_reserved(k);
            end
            cursor = FIRST_ID;
        endfunction

        // Next-fit scan from cursor+1, wrapping to the first identifier; the
        // cursor entry itself is tested last.
        function t_id_result predict_grant();
            t_id_result  res;
            int unsigned pos;
            res.granted = '0;
            res.status  = ST_EXHAUSTED;
            pos         = cursor;
            for (int n = 0; n < POOL_SIZE - 1; n++) begin
                pos++;
                if (pos >= POOL_SIZE) begin
                    pos = FIRST_ID;
                end
                if (!used_map[pos]) begin
                    used_map[pos] = 1'b1;
                    cursor        = pos;
                    res.granted   = ID_W'(pos);
                    res.status    = ST_DONE;
                    return res;
                end
            end
            return res;
        endfunction

        // Called for every accepted request.
        function void note_request(logic [1:0] kind, logic [ID_W-1:0] id);
            t_id_result res;
            res.granted = '0;
            res.status  = ST_DONE;
            case (kind)
                KIND_ALLOC: begin
                    res = predict_grant();
                end
                KIND_RELEASE: begin
                    if (id < FIRST_ID || int'(id) >= POOL_SIZE) begin
                        res.status = ST_RANGE;
                    end else begin
                        used_map[id] = is_reserved(id);
                    end
                end
                KIND_RESET: begin
                    restore_pool();
                end
                default: begin
                end
            endcase
            pending_results.push_back(res);
        endfunction

        // Called for every result strobe.
        function void check_result(logic [ID_W-1:0] granted, logic [1:0] status);
            t_id_result exp;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending: granted_id %0d status %0d",
                         $time, granted, status);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (granted !== exp.granted) begin
                $display("%0t: granted_id mismatch: expected %0d, actual %0d",
                         $time, exp.granted, granted);
                errors++;
            end
            if (status !== exp.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, exp.status, status);
                errors++;
            end
        endfunction

        function void report_leftovers();
            if (pending_results.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, pending_results.size());
                errors++;
            end
        endfunction
    endclass

    logic            i_clk    = 1'b0;
    logic            i_rst_n  = 1'b0;
    logic            start    = 1'b0;
    logic [1:0]      i_kind   = KIND_ALLOC;
    logic [ID_W-1:0] i_req_id = '0;
    logic            busy;
    logic            o_done;
    logic [ID_W-1:0] o_granted_id;
    logic [1:0]      o_status;

    id_pool_scoreboard sb;
    bit                idling_on;

    next_fit_id_allocator_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_req_id     (i_req_id),
        .o_done       (o_done),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Sample at the clock edge: results first, then the request accepted at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_granted_id, o_status);
        end
        if (i_rst_n && start && !busy) begin
            sb.note_request(i_kind, i_req_id);
        end
    end

    // Drop start for a random burst of cycles.
    task automatic idle_burst();
        int unsigned gap;
        gap = $urandom_range(1, 17);
        start <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Present one request and return at the edge that accepts it; start stays high.
    task automatic issue_request(logic [1:0] kind, logic [ID_W-1:0] id);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            idle_burst();
        end
        start    <= 1'b1;
        i_kind   <= kind;
        i_req_id <= id;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off new requests until every owed result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly releases identifiers just behind the cursor, which are likely in use.
    function automatic logic [ID_W-1:0] pick_release_id();
        int unsigned sel;
        int unsigned back;
        sel  = $urandom_range(0, 7);
        back = $urandom_range(0, 48);
        if (sel == 0) begin
            return '0;
        end
        if (sel <= 2) begin
            return ID_W'($urandom_range(1, POOL_SIZE - 1));
        end
        return ID_W'(((sb.cursor + POOL_SIZE - 2 - back) % (POOL_SIZE - 1)) + 1);
    endfunction

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned counted;
        int unsigned sel;
        int unsigned streak;
        logic [ID_W-1:0] rel_id;

        sb        = new();
        idling_on = 1'b1;
        counted   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: field extremes, every kind and the special cases.
        issue_request(KIND_ALLOC, 10'd1023);
        issue_request(KIND_ALLOC, 10'd0);
        issue_request(KIND_RELEASE, 10'd0);       // out of range
        issue_request(KIND_RELEASE, 10'd13);      // reserved stays used
        issue_request(KIND_RELEASE, 10'd781);     // reserved stays used
        issue_request(KIND_RELEASE, 10'd2);
        issue_request(KIND_RELEASE, 10'd2);       // already free
        issue_request(KIND_RELEASE, 10'd1023);    // top identifier, already free
        issue_request(KIND_ALLOC, 10'h155);       // next fit does not go back to 2
        issue_request(KIND_NOP, 10'd1023);
        issue_request(KIND_NOP, 10'd0);
        issue_request(KIND_RELEASE, 10'd3);
        issue_request(KIND_RESET, 10'd1023);
        issue_request(KIND_ALLOC, 10'h2AA);
        issue_request(KIND_RELEASE, 10'd1);
        issue_request(KIND_ALLOC, 10'd0);
        issue_request(KIND_ALLOC, 10'd0);
        issue_request(KIND_RESET, 10'd0);
        issue_request(KIND_ALLOC, 10'd0);

        // Fill the pool to exhaustion, then free the cursor entry so that it is
        // the only free one and must be granted again.
        idling_on = 1'b0;
        issue_request(KIND_RESET, 10'd0);
        repeat (POOL_SIZE - 5) issue_request(KIND_ALLOC, ID_W'($urandom));
        issue_request(KIND_ALLOC, 10'd0);
        issue_request(KIND_ALLOC, 10'd0);
        wait_drained();
        issue_request(KIND_RELEASE, ID_W'(sb.cursor));
        issue_request(KIND_ALLOC, 10'd0);
        issue_request(KIND_ALLOC, 10'd0);
        idling_on = 1'b1;
        repeat (3) issue_request(KIND_RELEASE, ID_W'($urandom_range(1, POOL_SIZE - 1)));
        repeat (4) issue_request(KIND_ALLOC, ID_W'($urandom));
        wait_drained();
        issue_request(KIND_RESET, ID_W'($urandom));

        // Random mix; stretches with and without idling chosen at random, none at the end.
        while (counted < RANDOM_ITEMS) begin
            if (counted % 60 == 0) begin
                idling_on = (counted < RANDOM_ITEMS - 150) && ($urandom_range(0, 3) != 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                streak = $urandom_range(20, 120);
                repeat (streak) issue_request(KIND_ALLOC, ID_W'($urandom));
                counted += streak;
            end else if (sel < 55) begin
                issue_request(KIND_ALLOC, ID_W'($urandom));
                counted++;
            end else if (sel < 90) begin
                rel_id = pick_release_id();
                issue_request(KIND_RELEASE, rel_id);
                if (rel_id != 0) begin
                    counted++;
                end
            end else if (sel < 95) begin
                issue_request(KIND_RESET, ID_W'($urandom));
                counted++;
            end else begin
                issue_request(KIND_NOP, ID_W'($urandom));
            end
        end

        // Let the last results come back, then settle.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
